FILE: rtl/bcs_pkg.sv
package bcs_pkg;

    // Character codes the scanner looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_LINE
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_PUSH_WS,
        CMD_POP,
        CMD_PRODUCE,
        CMD_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic emit_left;
        logic emit_ws;
        logic held_empty;
        logic held_full;
        logic can_produce;
        logic out_free;
        logic eob;
        logic drop;
    } t_status;

    function automatic logic is_ws(input logic [7:0] b);
        return b inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

endpackage

FILE: rtl/block_comment_stripper.sv
// Block comment stripper: takes one text byte per input word and returns the same text with
// every C block comment (delimiters and newlines included) turned into spaces. Double-quoted
// strings (backslash escapes, ended by a quote or newline) and line comments starting at the
// byte written to the configuration register (zero disables) shield their contents. A slash is
// held back one byte to spot a comment opener. Block-comment state carries across buffers and
// is cleared by start_of_file; string and line-comment state end with each buffer. Whitespace
// runs are parked in a HOLD_DEPTH-byte store; if the buffer had anything blanked, trailing
// whitespace is dropped at end_of_buffer, otherwise it is released. When the store overflows
// the oldest byte is sent out and can no longer be trimmed. The last word of every buffer
// carries buffer_done, was_changed and block_open; a buffer end that yields no byte gives one
// word with has_byte low. Items are handled one at a time: each is accepted, then every byte
// sent out of the scanner or released from the whitespace store is handled in turn (one store
// access per cycle), and the item closes once the output side is free. The input stall is high
// while an item is in progress. Write the configuration register only while the block is idle.
module block_comment_stripper #(
    parameter int HOLD_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    // input words
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    input  logic       i_start_of_file,
    // output words
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_buffer_done,
    output logic       o_was_changed,
    output logic       o_block_open
);
    import bcs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer: accept, walk the emit list and store flushes, close the item
    bcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Scanner, whitespace store, pending slot and output register
    bcs_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_start_of_file (i_start_of_file),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_buffer_done   (o_buffer_done),
        .o_was_changed   (o_was_changed),
        .o_block_open    (o_block_open)
    );

endmodule

FILE: rtl/bcs_ctrl.sv
module bcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bcs_pkg::t_status i_status,
    output logic            o_stall,
    output bcs_pkg::t_cmd   o_cmd
);
    import bcs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_status.emit_left &&
                    (!i_status.eob || i_status.drop || i_status.held_empty)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.op = CMD_NONE;
        o_stall  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = CMD_ACCEPT;
                end
            end
            ST_RUN: begin
                if (i_status.emit_left) begin
                    if (i_status.emit_ws) begin
                        // full store pushes its oldest byte out first
                        if (!i_status.held_full || i_status.can_produce) begin
                            o_cmd.op = CMD_PUSH_WS;
                        end
                    end else if (i_status.can_produce) begin
                        o_cmd.op = i_status.held_empty ? CMD_PRODUCE : CMD_POP;
                    end
                end else if (i_status.eob && !i_status.drop && !i_status.held_empty &&
                             i_status.can_produce) begin
                    o_cmd.op = CMD_POP;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.op = CMD_FINISH;
                end
            end
            default: o_cmd.op = CMD_NONE;
        endcase
    end

endmodule

FILE: rtl/bcs_datapath.sv
module bcs_datapath #(
    parameter int HOLD_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_buffer,
    input  logic             i_start_of_file,
    input  logic             i_stall,
    input  bcs_pkg::t_cmd    i_cmd,
    output bcs_pkg::t_status o_status,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_has_byte,
    output logic             o_buffer_done,
    output logic             o_was_changed,
    output logic             o_block_open
);
    import bcs_pkg::*;

    localparam int PTR_W = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HOLD_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HOLD_DEPTH - 1);
    localparam logic [CNT_W:0]   WRAP_SUM = (CNT_W + 1)'(HOLD_DEPTH);

    // Configuration and scanner state
    logic [7:0] r_lcc;
    t_mode      r_mode;
    logic       r_in_block;
    logic       r_star;
    logic       r_slash;
    logic       r_changed;

    // Current item: up to two bytes to emit plus buffer-end flags
    logic [7:0] r_em0;
    logic [7:0] r_em1;
    logic [1:0] r_nem;
    logic [1:0] r_idx;
    logic       r_eob;
    logic       r_chg;
    logic       r_blk;

    // Whitespace hold store (circular)
    logic [7:0]       r_mem [HOLD_DEPTH];
    logic [7:0]       r_rd;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Pending result and output register
    logic       r_pend_valid;
    logic       n_pend_valid;
    logic [7:0] r_pend_byte;
    logic [7:0] n_pend_byte;
    logic       r_out_valid;

    // Decode of the incoming word
    t_mode      d_mode;
    logic       d_ib;
    logic       d_st;
    logic       d_slash;
    logic       d_chg;
    logic       d_opened;
    logic [7:0] d_e0;
    logic [7:0] d_e1;
    logic [1:0] d_n;

    logic [7:0]       cur_byte;
    logic [CNT_W:0]   tail_sum;
    logic [CNT_W:0]   tail_wrap;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head_inc;
    logic             held_full;
    logic             held_empty;
    logic             out_free;
    logic             wr_en;
    logic             prod;
    logic [7:0]       prod_byte;
    logic             idx_adv;
    logic             load;
    logic [7:0]       ld_byte;
    logic             ld_has;
    logic             ld_done;
    logic             ld_chg;
    logic             ld_blk;

    always_comb begin
        d_ib     = i_start_of_file ? 1'b0 : r_in_block;
        d_st     = i_start_of_file ? 1'b0 : r_star;
        d_slash  = r_slash;
        d_chg    = r_changed;
        d_mode   = r_mode;
        d_opened = 1'b0;
        d_e0     = CH_NUL;
        d_e1     = CH_NUL;
        d_n      = 2'd0;
        if (i_data_byte != CH_NUL) begin
            if (d_ib) begin
                d_e0  = CH_SPACE;
                d_n   = 2'd1;
                d_chg = 1'b1;
                if (d_st && i_data_byte == CH_SLASH) begin
                    d_ib = 1'b0;
                    d_st = 1'b0;
                end else begin
                    d_st = (i_data_byte == CH_STAR);
                end
            end else begin
                case (d_mode)
                    MODE_STRING: begin
                        if (i_data_byte == CH_BSLASH) begin
                            d_mode = MODE_ESCAPE;
                        end else if (i_data_byte == CH_NL || i_data_byte == CH_QUOTE) begin
                            d_mode = MODE_NORMAL;
                        end
                        d_e0 = i_data_byte;
                        d_n  = 2'd1;
                    end
                    MODE_ESCAPE: begin
                        d_mode = MODE_STRING;
                        d_e0   = i_data_byte;
                        d_n    = 2'd1;
                    end
                    MODE_LINE: begin
                        if (i_data_byte == CH_NL) begin
                            d_mode = MODE_NORMAL;
                        end
                        d_e0 = i_data_byte;
                        d_n  = 2'd1;
                    end
                    default: begin
                        if (d_slash) begin
                            d_slash = 1'b0;
                            if (i_data_byte == CH_STAR) begin
                                d_e0     = CH_SPACE;
                                d_e1     = CH_SPACE;
                                d_n      = 2'd2;
                                d_ib     = 1'b1;
                                d_st     = 1'b0;
                                d_chg    = 1'b1;
                                d_opened = 1'b1;
                            end else begin
                                d_e0 = CH_SLASH;
                                d_n  = 2'd1;
                            end
                        end
                        if (!d_opened) begin
                            if (i_data_byte == CH_QUOTE ||
                                (r_lcc != CH_NUL && i_data_byte == r_lcc)) begin
                                if (i_data_byte == CH_QUOTE) begin
                                    d_mode = MODE_STRING;
                                end else if (i_data_byte != CH_NL) begin
                                    d_mode = MODE_LINE;
                                end
                                if (d_n == 2'd0) begin
                                    d_e0 = i_data_byte;
                                end else begin
                                    d_e1 = i_data_byte;
                                end
                                d_n = d_n + 2'd1;
                            end else if (i_data_byte == CH_SLASH) begin
                                d_slash = 1'b1;
                            end else begin
                                if (d_n == 2'd0) begin
                                    d_e0 = i_data_byte;
                                end else begin
                                    d_e1 = i_data_byte;
                                end
                                d_n = d_n + 2'd1;
                            end
                        end
                    end
                endcase
            end
        end
        // flush a held-back slash at buffer end
        if (i_end_of_buffer && d_slash) begin
            d_slash = 1'b0;
            if (d_n == 2'd0) begin
                d_e0 = CH_SLASH;
            end else begin
                d_e1 = CH_SLASH;
            end
            d_n = d_n + 2'd1;
        end
    end

    assign cur_byte   = (r_idx == 2'd0) ? r_em0 : r_em1;
    assign tail_sum   = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_count);
    assign tail_wrap  = (tail_sum >= WRAP_SUM) ? (tail_sum - WRAP_SUM) : tail_sum;
    assign tail       = tail_wrap[PTR_W-1:0];
    assign head_inc   = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
    assign held_full  = (r_count == FULL_CNT);
    assign held_empty = (r_count == '0);
    assign out_free   = !r_out_valid || !i_stall;

    // Hold store moves
    always_comb begin
        wr_en     = 1'b0;
        n_head    = r_head;
        n_count   = r_count;
        prod      = 1'b0;
        prod_byte = r_rd;
        idx_adv   = 1'b0;
        case (i_cmd.op)
            CMD_PUSH_WS: begin
                wr_en   = 1'b1;
                idx_adv = 1'b1;
                if (held_full) begin
                    prod   = 1'b1;
                    n_head = head_inc;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP: begin
                prod    = 1'b1;
                n_head  = head_inc;
                n_count = r_count - 1'b1;
            end
            CMD_PRODUCE: begin
                prod      = 1'b1;
                prod_byte = cur_byte;
                idx_adv   = 1'b1;
            end
            CMD_FINISH: begin
                if (r_eob) begin
                    n_count = '0;
                end
            end
            default: ;
        endcase
    end

    // A result waits in the pending slot until we know whether it closes the buffer
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        load         = 1'b0;
        ld_byte      = r_pend_byte;
        ld_has       = 1'b1;
        ld_done      = 1'b0;
        ld_chg       = 1'b0;
        ld_blk       = 1'b0;
        if (prod) begin
            load         = r_pend_valid;
            n_pend_valid = 1'b1;
            n_pend_byte  = prod_byte;
        end
        if (i_cmd.op == CMD_FINISH) begin
            if (r_pend_valid) begin
                load         = 1'b1;
                n_pend_valid = 1'b0;
                ld_done      = r_eob;
                ld_chg       = r_eob & r_chg;
                ld_blk       = r_eob & r_blk;
            end else if (r_eob) begin
                load    = 1'b1;
                ld_byte = CH_NUL;
                ld_has  = 1'b0;
                ld_done = 1'b1;
                ld_chg  = r_chg;
                ld_blk  = r_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcc        <= CH_NUL;
            r_mode       <= MODE_NORMAL;
            r_in_block   <= 1'b0;
            r_star       <= 1'b0;
            r_slash      <= 1'b0;
            r_changed    <= 1'b0;
            r_nem        <= 2'd0;
            r_idx        <= 2'd0;
            r_eob        <= 1'b0;
            r_chg        <= 1'b0;
            r_blk        <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lcc <= i_cfg_data;
            end
            if (i_cmd.op == CMD_ACCEPT) begin
                r_mode     <= i_end_of_buffer ? MODE_NORMAL : d_mode;
                r_in_block <= d_ib;
                r_star     <= i_end_of_buffer ? 1'b0 : d_st;
                r_slash    <= d_slash;
                r_changed  <= i_end_of_buffer ? 1'b0 : d_chg;
                r_nem      <= d_n;
                r_idx      <= 2'd0;
                r_eob      <= i_end_of_buffer;
                r_chg      <= d_chg;
                r_blk      <= d_ib;
            end else if (idx_adv) begin
                r_idx <= r_idx + 2'd1;
            end
            r_head       <= n_head;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: emit bytes, pending byte, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_ACCEPT) begin
            r_em0 <= d_e0;
            r_em1 <= d_e1;
        end
        r_pend_byte <= n_pend_byte;
        if (load) begin
            o_out_byte    <= ld_byte;
            o_has_byte    <= ld_has;
            o_buffer_done <= ld_done;
            o_was_changed <= ld_chg;
            o_block_open  <= ld_blk;
        end
    end

    // Hold store memory; read port follows the next head, bypass a same-cycle write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[tail] <= cur_byte;
        end
        r_rd <= (wr_en && tail == n_head) ? cur_byte : r_mem[n_head];
    end

    assign o_valid              = r_out_valid;
    assign o_status.emit_left   = (r_idx != r_nem);
    assign o_status.emit_ws     = is_ws(cur_byte);
    assign o_status.held_empty  = held_empty;
    assign o_status.held_full   = held_full;
    assign o_status.can_produce = !r_pend_valid || out_free;
    assign o_status.out_free    = out_free;
    assign o_status.eob         = r_eob;
    assign o_status.drop        = r_chg;

endmodule

FILE: rtl/bcs_checker.sv
module bcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_has_byte,
    input logic       o_buffer_done,
    input logic       o_was_changed,
    input logic       o_block_open
);

    // A word without a byte only closes a buffer, and carries a zero byte
    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_buffer_done && o_out_byte == 8'h00)
        else $error("bare word without buffer_done");

    // Flags only show on the last word of a buffer
    a_flags_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_buffer_done |-> !o_was_changed && !o_block_open)
        else $error("flags set on a word that does not close a buffer");

    // An accepted word keeps the input busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after an accept");

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_buffer_done))
        else $error("stalled output word changed");

endmodule

bind block_comment_stripper bcs_checker u_bcs_checker (.*);

FILE: dv/block_comment_stripper_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for block_comment_stripper. A directed script runs first,
// then randomized text buffers built from comment, string, whitespace and noise
// tokens. Every accepted input word goes through a local prediction of the
// stripper, and every accepted output word is matched against the oldest
// prediction still waiting.
module block_comment_stripper_tb;
    import bcs_pkg::*;

    localparam int          HOLD_DEPTH    = 32;
    localparam int          SETTLE_CYCLES = 16;     // covers one item with no output word
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          SEG_ITEMS     = 28;     // random words per configuration segment
    localparam int          SCRIPT_LEN    = 29;

    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_B = 8'h62;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // One output word as the block presents it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       buffer_done;
        logic       was_changed;
        logic       block_open;
    } t_word;

    localparam t_word NO_WORD = '0;

    // One step of the directed script; want is used only where typed is set
    typedef struct {
        logic [7:0] data;
        bit         eob;
        bit         sof;
        bit         typed;
        t_word      want;
    } t_step;

    // Comment character for each random segment: none, the two comment
    // delimiters, newline, quote and the top code
    localparam logic [7:0] SEG_CHAR [6] = '{8'h00, CH_SLASH, CH_STAR, CH_NL, CH_QUOTE, 8'hFF};

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic [7:0] i_cfg_data      = 8'h00;
    logic       i_valid         = 1'b0;
    logic [7:0] i_data_byte     = 8'h00;
    logic       i_end_of_buffer = 1'b0;
    logic       i_start_of_file = 1'b0;
    logic       i_stall         = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_has_byte;
    logic       o_buffer_done;
    logic       o_was_changed;
    logic       o_block_open;

    // Shadow state of the stripper
    logic [7:0] comment_char = 8'h00;
    t_mode      scan_mode    = MODE_NORMAL;
    bit         in_block     = 1'b0;
    bit         star_seen    = 1'b0;
    bit         slash_held   = 1'b0;
    bit         blanked      = 1'b0;
    logic [7:0] ws_run[$];

    t_word       item_words[$];    // words caused by the item being predicted
    t_word       stripped_fifo[$]; // words predicted but not yet seen
    int          mismatches   = 0;
    int          items_sent   = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int unsigned cycle_count  = 0;

    block_comment_stripper #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .i_start_of_file(i_start_of_file),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_has_byte     (o_has_byte),
        .o_buffer_done  (o_buffer_done),
        .o_was_changed  (o_was_changed),
        .o_block_open   (o_block_open)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case a word never shows up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("block_comment_stripper verification failed");
            $finish;
        end
    end

    // Receiver: stall at random, decided at the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic bit is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    task automatic add_word(input logic [7:0] b, input bit has);
        t_word w;
        w          = NO_WORD;
        w.out_byte = has ? b : CH_NUL;
        w.has_byte = has;
        item_words.push_back(w);
    endtask

    task automatic release_spaces();
        while (ws_run.size() != 0) add_word(ws_run.pop_front(), 1'b1);
    endtask

    // Park whitespace so trailing runs can be trimmed; release the run ahead of
    // anything else. A full store lets go of its oldest byte for good.
    task automatic hold_or_pass(input logic [7:0] b);
        if (is_space(b)) begin
            if (ws_run.size() >= HOLD_DEPTH) add_word(ws_run.pop_front(), 1'b1);
            ws_run.push_back(b);
        end else begin
            release_spaces();
            add_word(b, 1'b1);
        end
    endtask

    task automatic scan_char(input logic [7:0] b);
        // Inside a block comment everything turns into a space until the closer
        if (in_block) begin
            hold_or_pass(CH_SPACE);
            blanked = 1'b1;
            if (star_seen && b == CH_SLASH) begin
                in_block  = 1'b0;
                star_seen = 1'b0;
            end else begin
                star_seen = (b == CH_STAR);
            end
            return;
        end
        // Strings and line comments shield their contents
        case (scan_mode)
            MODE_STRING: begin
                if (b == CH_BSLASH) scan_mode = MODE_ESCAPE;
                else if (b == CH_NL || b == CH_QUOTE) scan_mode = MODE_NORMAL;
                hold_or_pass(b);
                return;
            end
            MODE_ESCAPE: begin
                scan_mode = MODE_STRING;
                hold_or_pass(b);
                return;
            end
            MODE_LINE: begin
                if (b == CH_NL) scan_mode = MODE_NORMAL;
                hold_or_pass(b);
                return;
            end
            default: ;
        endcase
        // A held slash either opens a block or goes out as itself
        if (slash_held) begin
            slash_held = 1'b0;
            if (b == CH_STAR) begin
                hold_or_pass(CH_SPACE);
                hold_or_pass(CH_SPACE);
                in_block  = 1'b1;
                star_seen = 1'b0;
                blanked   = 1'b1;
                return;
            end
            hold_or_pass(CH_SLASH);
        end
        // Quote beats the comment character; a newline comment char is empty
        if (b == CH_QUOTE) begin
            scan_mode = MODE_STRING;
            hold_or_pass(b);
        end else if (comment_char != CH_NUL && b == comment_char) begin
            if (b != CH_NL) scan_mode = MODE_LINE;
            hold_or_pass(b);
        end else if (b == CH_SLASH) begin
            slash_held = 1'b1;
        end else begin
            hold_or_pass(b);
        end
    endtask

    // Work out the words one input word causes
    task automatic strip_byte(input logic [7:0] b, input bit eob, input bit sof);
        t_word last;
        item_words.delete();
        if (sof) begin
            in_block  = 1'b0;
            star_seen = 1'b0;
        end
        if (b != CH_NUL) scan_char(b);
        if (eob) begin
            if (slash_held) begin
                slash_held = 1'b0;
                hold_or_pass(CH_SLASH);
            end
            // Trim trailing whitespace only when something was blanked
            if (blanked) ws_run.delete();
            else release_spaces();
            if (item_words.size() == 0) add_word(CH_NUL, 1'b0);
            last             = item_words.pop_back();
            last.buffer_done = 1'b1;
            last.was_changed = blanked;
            last.block_open  = in_block;
            item_words.push_back(last);
            blanked   = 1'b0;
            scan_mode = MODE_NORMAL;
            star_seen = 1'b0;
            ws_run.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check_words
        t_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (stripped_fifo.size() == 0) begin
                $error("unexpected word: out_byte %h has_byte %b", o_out_byte, o_has_byte);
                mismatches++;
            end else begin
                want = stripped_fifo.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, o_out_byte);
                    mismatches++;
                end
                if (o_has_byte !== want.has_byte) begin
                    $error("has_byte: expected %b, got %b", want.has_byte, o_has_byte);
                    mismatches++;
                end
                if (o_buffer_done !== want.buffer_done) begin
                    $error("buffer_done: expected %b, got %b", want.buffer_done, o_buffer_done);
                    mismatches++;
                end
                if (o_was_changed !== want.was_changed) begin
                    $error("was_changed: expected %b, got %b", want.was_changed, o_was_changed);
                    mismatches++;
                end
                if (o_block_open !== want.block_open) begin
                    $error("block_open: expected %b, got %b", want.block_open, o_block_open);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one word, hold it until accepted, then predict. A typed word stands
    // in for the prediction where the answer is plain to see.
    task automatic send_item(input logic [7:0] b, input bit eob, input bit sof,
                             input bit typed = 1'b0, input t_word want = '0);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        i_start_of_file <= sof;
        do @(posedge i_clk); while (o_stall);
        strip_byte(b, eob, sof);
        if (typed) stripped_fifo.push_back(want);
        else stripped_fifo = {stripped_fifo, item_words};
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic drain_words();
        i_valid <= 1'b0;
        while (stripped_fifo.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_comment_char(input logic [7:0] c);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        comment_char  = c;
    endtask

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 3))
            0:       return CH_LO_A + 8'($urandom_range(0, 25));
            1:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 6))
            0, 1:    return CH_SPACE;
            2:       return CH_TAB;
            3:       return CH_NL;
            4:       return CH_VT;
            5:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // Bytes that steer the scanner, mixed with plain text and whitespace
    function automatic logic [7:0] pick_mark();
        case ($urandom_range(0, 8))
            0:       return CH_SLASH;
            1:       return CH_STAR;
            2:       return CH_QUOTE;
            3:       return CH_BSLASH;
            4:       return CH_NL;
            5:       return (comment_char != CH_NUL) ? comment_char : CH_HASH;
            6:       return pick_space();
            default: return pick_text();
        endcase
    endfunction

    // Build one buffer from tokens and send it; end it on its last byte or on
    // a bare end marker, with the odd stray zero thrown in
    task automatic send_random_buffer();
        logic [7:0] text[$];
        int         len;
        bit         bare_end;
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 6)) text.push_back(pick_text());
                end
                3: begin
                    // block comment, left open now and then
                    text.push_back(CH_SLASH);
                    text.push_back(CH_STAR);
                    repeat ($urandom_range(0, 5)) text.push_back(pick_mark());
                    if ($urandom_range(0, 4) != 0) begin
                        text.push_back(CH_STAR);
                        text.push_back(CH_SLASH);
                    end
                end
                4: begin
                    // string with escapes, closed by quote, newline or nothing
                    text.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            text.push_back(CH_BSLASH);
                            text.push_back(pick_mark());
                        end else begin
                            text.push_back(pick_text());
                        end
                    end
                    case ($urandom_range(0, 5))
                        0:       text.push_back(CH_NL);
                        1:       ;
                        default: text.push_back(CH_QUOTE);
                    endcase
                end
                5: begin
                    // whitespace run, long enough now and then to overflow the store
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(HOLD_DEPTH - 4, HOLD_DEPTH + 8)
                                                      : $urandom_range(1, 6);
                    repeat (len) text.push_back(pick_space());
                end
                6: begin
                    text.push_back((comment_char != CH_NUL) ? comment_char : CH_HASH);
                    repeat ($urandom_range(0, 4)) text.push_back(pick_mark());
                    if ($urandom_range(0, 9) < 7) text.push_back(CH_NL);
                end
                7: text.push_back(pick_mark());
                8: text.push_back(8'($urandom_range(1, 255)));
                default: begin
                    text.push_back(CH_STAR);
                    text.push_back(CH_SLASH);
                end
            endcase
        end
        bare_end = (text.size() == 0) || ($urandom_range(0, 5) == 0);
        foreach (text[i]) begin
            if ($urandom_range(0, 39) == 0) send_item(CH_NUL, 1'b0, 1'($urandom_range(0, 1)));
            send_item(text[i], !bare_end && (i == text.size() - 1), $urandom_range(0, 24) == 0);
            items_sent++;
        end
        if (bare_end) begin
            send_item(CH_NUL, 1'b1, $urandom_range(0, 24) == 0);
            items_sent++;
        end
    endtask

    // Directed script, run with '#' as the comment character
    t_step script [SCRIPT_LEN] = '{
        // bare end, then single-byte buffers including the extremes, right after reset
        '{CH_NUL,    1'b1, 1'b0, 1'b1, '{CH_NUL,  1'b0, 1'b1, 1'b0, 1'b0}},
        '{8'h41,     1'b1, 1'b0, 1'b1, '{8'h41,   1'b1, 1'b1, 1'b0, 1'b0}},
        '{8'hFF,     1'b1, 1'b0, 1'b1, '{8'hFF,   1'b1, 1'b1, 1'b0, 1'b0}},
        '{8'h01,     1'b1, 1'b1, 1'b1, '{8'h01,   1'b1, 1'b1, 1'b0, 1'b0}},
        // a block comment over a newline, trailing whitespace trimmed
        '{CH_LO_A,   1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,   1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_NL,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,   1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_TAB,    1'b1, 1'b0, 1'b0, NO_WORD},
        // opener inside a string, escaped quote
        '{CH_QUOTE,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,   1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_QUOTE,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_QUOTE,  1'b0, 1'b0, 1'b0, NO_WORD},
        // line comment shields a quote; slash pending at buffer end
        '{CH_HASH,   1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_QUOTE,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_NL,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_SLASH,  1'b1, 1'b0, 1'b0, NO_WORD},
        // star closing a buffer inside a block does not pair across buffers
        '{CH_SLASH,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,   1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_STAR,   1'b1, 1'b0, 1'b0, NO_WORD},
        '{CH_SLASH,  1'b1, 1'b0, 1'b0, NO_WORD},
        // stray zero with start of file clears the open block
        '{CH_NUL,    1'b0, 1'b1, 1'b0, NO_WORD},
        // backslash ending a buffer escapes nothing
        '{CH_QUOTE,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{CH_BSLASH, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{CH_LO_B,   1'b1, 1'b0, 1'b0, NO_WORD}
    };

    initial begin
        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct   = 30;
        stall_pct = 61;
        set_comment_char(CH_HASH);
        foreach (script[i]) begin
            send_item(script[i].data, script[i].eob, script[i].sof, script[i].typed, script[i].want);
        end

        // Random segments: receiver-heavy stalling, then sender-heavy idling, then none.
        // Each segment starts from an idle block with a new comment character.
        for (int seg = 0; seg < 6; seg++) begin
            drain_words();
            set_comment_char(SEG_CHAR[seg]);
            case (seg / 2)
                0: begin
                    gap_pct   = 30;
                    stall_pct = 61;
                end
                1: begin
                    gap_pct   = 61;
                    stall_pct = 30;
                end
                default: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            while (items_sent < SEG_ITEMS * (seg + 1)) send_random_buffer();
        end

        drain_words();
        if (mismatches == 0) begin
            $display("block_comment_stripper verification clean");
        end else begin
            $display("block_comment_stripper verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bcs_pkg.sv
rtl/bcs_ctrl.sv
rtl/bcs_datapath.sv
rtl/block_comment_stripper.sv
rtl/bcs_checker.sv
dv/block_comment_stripper_tb.sv
